// ===== design/cfd_pkg.sv =====
// Shared types and constants for the checksum frame deframer.
// Depends on nothing; every other design file imports it.
`default_nettype none

package cfd_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEAD_FIRST_RST  = 8'h57;
    localparam logic [BYTE_W-1:0] HEAD_SECOND_RST = 8'hAB;

    // Register indexes (paddr[2] selects the word)
    localparam logic REG_HEAD_FIRST  = 1'b0;
    localparam logic REG_HEAD_SECOND = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUM_GOOD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM_BAD  = 2'd2;

    // Framing phase, one-hot
    typedef enum logic [6:0] {
        PH_HUNT1 = 7'b0000001,
        PH_HUNT2 = 7'b0000010,
        PH_ADDR  = 7'b0000100,
        PH_CMD   = 7'b0001000,
        PH_LEN   = 7'b0010000,
        PH_DATA  = 7'b0100000,
        PH_SUM   = 7'b1000000
    } cfd_phase_t;

    // Header match values from the register file
    typedef struct packed {
        logic [BYTE_W-1:0] head_first;
        logic [BYTE_W-1:0] head_second;
    } cfd_cfg_t;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] dev_addr;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] payload_len;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] payload_byte;
    } cfd_result_t;

    // Core to output stage: load strobe and result
    typedef struct packed {
        logic        load;
        cfd_result_t res;
    } cfd_emit_t;

endpackage

`default_nettype wire

// ===== design/cfd_byte_if.sv =====
// Input channel interface: one received byte per request.
// Depends on cfd_pkg.
`default_nettype none

interface cfd_byte_if;
    import cfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/cfd_result_if.sv =====
// Output channel interface: payload bytes and frame-end results.
// Depends on cfd_pkg.
`default_nettype none

interface cfd_result_if;
    import cfd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] dev_addr;
    logic [BYTE_W-1:0] command;
    logic [BYTE_W-1:0] payload_len;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] payload_byte;

    modport source (output valid, output kind, output dev_addr, output command,
                    output payload_len, output byte_index, output payload_byte,
                    input ready);
    modport sink   (input valid, input kind, input dev_addr, input command,
                    input payload_len, input byte_index, input payload_byte,
                    output ready);
endinterface

`default_nettype wire

// ===== design/cfd_cfg_regs.sv =====
// APB register file holding the two header match bytes.
// Depends on cfd_pkg.
`default_nettype none

module cfd_cfg_regs
(
    input  wire                                logic clk,
    input  wire                                logic rst_n,
    input  wire                                logic psel,
    input  wire                                logic penable,
    input  wire                                logic pwrite,
    input  wire  logic [cfd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire  logic [cfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cfd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    output cfd_pkg::cfd_cfg_t                    cfg
);
    import cfd_pkg::*;

    logic [BYTE_W-1:0] head_first_reg;
    logic [BYTE_W-1:0] head_second_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Write the addressed header byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_first_reg  <= HEAD_FIRST_RST;
            head_second_reg <= HEAD_SECOND_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_HEAD_FIRST)
                head_first_reg <= pwdata[BYTE_W-1:0];
            else
                head_second_reg <= pwdata[BYTE_W-1:0];
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (paddr[2])
            REG_HEAD_FIRST:  prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, head_first_reg};
            REG_HEAD_SECOND: prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, head_second_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.head_first  = head_first_reg;
    assign cfg.head_second = head_second_reg;

endmodule

`default_nettype wire

// ===== design/cfd_core.sv =====
// Input byte register and framing state machine with running checksum.
// Depends on cfd_pkg and cfd_byte_if.
`default_nettype none

module cfd_core
(
    input  wire  logic              clk,
    input  wire  logic              rst_n,
    cfd_byte_if.sink                rx,
    input  wire  cfd_pkg::cfd_cfg_t cfg,
    input  wire  logic              out_free,
    output cfd_pkg::cfd_emit_t      emit
);
    import cfd_pkg::*;

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    cfd_phase_t        phase_reg, phase_next;
    logic [BYTE_W-1:0] held_addr_reg, held_addr_next;
    logic [BYTE_W-1:0] held_command_reg, held_command_next;
    logic [BYTE_W-1:0] held_length_reg, held_length_next;
    logic [BYTE_W-1:0] payload_count_reg, payload_count_next;
    logic [BYTE_W-1:0] running_sum_reg, running_sum_next;
    logic [BYTE_W-1:0] count_inc;
    logic [BYTE_W-1:0] sum_add;
    logic              fire;
    logic              rx_take;

    // Process the held byte whenever the result slot can take a result
    assign fire    = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || fire;
    assign rx_take = rx.valid && rx.ready;

    // Hold the incoming byte
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (rx_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            byte_reg <= rx.rx_byte;
    end

    assign count_inc = payload_count_reg + 8'd1;
    assign sum_add   = running_sum_reg + byte_reg;

    // Advance the framing phase for one byte
    always_comb
    begin
        phase_next         = phase_reg;
        held_addr_next     = held_addr_reg;
        held_command_next  = held_command_reg;
        held_length_next   = held_length_reg;
        payload_count_next = payload_count_reg;
        running_sum_next   = running_sum_reg;

        emit.load             = 1'b0;
        emit.res.kind         = KIND_DATA;
        emit.res.dev_addr     = held_addr_reg;
        emit.res.command      = held_command_reg;
        emit.res.payload_len  = held_length_reg;
        emit.res.byte_index   = payload_count_reg;
        emit.res.payload_byte = byte_reg;

        if (fire)
        begin
            unique case (phase_reg)
                PH_HUNT2:
                begin
                    // Second header test wins when both values are equal
                    if (byte_reg == cfg.head_second)
                    begin
                        running_sum_next = sum_add;
                        phase_next       = PH_ADDR;
                    end
                    else if (byte_reg == cfg.head_first)
                        running_sum_next = byte_reg;
                    else
                        phase_next = PH_HUNT1;
                end
                PH_ADDR:
                begin
                    held_addr_next   = byte_reg;
                    running_sum_next = sum_add;
                    phase_next       = PH_CMD;
                end
                PH_CMD:
                begin
                    held_command_next = byte_reg;
                    running_sum_next  = sum_add;
                    phase_next        = PH_LEN;
                end
                PH_LEN:
                begin
                    held_length_next   = byte_reg;
                    payload_count_next = '0;
                    running_sum_next   = sum_add;
                    // Empty payload goes straight to the checksum byte
                    phase_next = (byte_reg == '0) ? PH_SUM : PH_DATA;
                end
                PH_DATA:
                begin
                    emit.load          = 1'b1;
                    running_sum_next   = sum_add;
                    payload_count_next = count_inc;
                    if (count_inc == held_length_reg)
                        phase_next = PH_SUM;
                end
                PH_SUM:
                begin
                    emit.load           = 1'b1;
                    emit.res.kind       = (byte_reg == running_sum_reg) ?
                                          KIND_SUM_GOOD : KIND_SUM_BAD;
                    emit.res.byte_index = '0;
                    phase_next          = PH_HUNT1;
                end
                default:
                begin
                    // Hunt for the first header byte
                    if (byte_reg == cfg.head_first)
                    begin
                        running_sum_next = byte_reg;
                        phase_next       = PH_HUNT2;
                    end
                    else
                        phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT1;
            held_addr_reg     <= '0;
            held_command_reg  <= '0;
            held_length_reg   <= '0;
            payload_count_reg <= '0;
            running_sum_reg   <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            held_addr_reg     <= held_addr_next;
            held_command_reg  <= held_command_next;
            held_length_reg   <= held_length_next;
            payload_count_reg <= payload_count_next;
            running_sum_reg   <= running_sum_next;
        end
    end

`ifndef SYNTH
    // Results come only from payload or checksum bytes
    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> (fire && (phase_reg == PH_DATA || phase_reg == PH_SUM)))
        else $error("result produced outside payload or checksum phase");

    // Payload count stays below the declared length while taking payload
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (payload_count_reg < held_length_reg))
        else $error("payload count reached declared length in payload phase");

    // Checksum byte always returns to hunting
    a_sum_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_SUM) |=> (phase_reg == PH_HUNT1))
        else $error("checksum byte did not return to hunting");
`endif

endmodule

`default_nettype wire

// ===== design/cfd_out_stage.sv =====
// Result register that parts the framing logic from the output channel.
// Depends on cfd_pkg and cfd_result_if.
`default_nettype none

module cfd_out_stage
(
    input  wire  logic               clk,
    input  wire  logic               rst_n,
    input  wire  cfd_pkg::cfd_emit_t emit,
    output logic                     out_free,
    cfd_result_if.source             tx
);
    import cfd_pkg::*;

    logic        valid_reg, valid_next;
    cfd_result_t res_reg;

    // Slot is free when empty or being drained this cycle
    assign out_free = !valid_reg || tx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit.load)
            valid_next = 1'b1;
        else if (tx.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load a new result
    always_ff @(posedge clk)
    begin
        if (emit.load)
            res_reg <= emit.res;
    end

    assign tx.valid        = valid_reg;
    assign tx.kind         = res_reg.kind;
    assign tx.dev_addr     = res_reg.dev_addr;
    assign tx.command      = res_reg.command;
    assign tx.payload_len  = res_reg.payload_len;
    assign tx.byte_index   = res_reg.byte_index;
    assign tx.payload_byte = res_reg.payload_byte;

endmodule

`default_nettype wire

// ===== design/checksum_frame_deframer_unit.sv =====
// Checksum frame deframer: top level.
// Channels: rx takes one received byte per request (valid/ready); tx
//   returns one result per payload byte and one per frame end (kind 0
//   payload, 1 checksum good, 2 checksum bad) with the frame's address,
//   command and length.
// Frame: two header bytes (head_first, head_second), address, command,
//   length, that many payload bytes, then an 8-bit wrapping sum of all
//   bytes from the first header byte through the last payload byte.
// Configuration: APB, head_first at 0x0 and head_second at 0x4, 8 bits
//   each, pready tied high; write only while the block is idle.
// Path: an accepted byte is held in the input byte register, processed when
//   the result slot is free and then registered in the result register for tx.
// Throughput: one byte per cycle while tx.ready is high, set by the input byte
//   register and the single result register.
// Reset: rst_n (asynchronous) empties both registers, returns to hunting
//   the first header byte and restores the header values 0x57 and 0xAB.
// Stall: a result held on tx keeps its value; one more byte is taken into
//   the input register, then rx.ready drops until tx.ready returns.
// Depends on cfd_pkg, cfd_byte_if, cfd_result_if and the cfd_* modules.
`default_nettype none

module checksum_frame_deframer_unit
(
    input  wire  logic                           clk,
    input  wire  logic                           rst_n,
    cfd_byte_if.sink                             rx,
    cfd_result_if.source                         tx,
    input  wire  logic                           psel,
    input  wire  logic                           penable,
    input  wire  logic                           pwrite,
    input  wire  logic [cfd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire  logic [cfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [cfd_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import cfd_pkg::*;

    cfd_cfg_t  cfg;
    cfd_emit_t emit;
    logic      out_free;

    // Header registers
    cfd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Framing logic
    cfd_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .cfg      (cfg),
        .out_free (out_free),
        .emit     (emit)
    );

    // Result register
    cfd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .out_free (out_free),
        .tx       (tx)
    );

endmodule

`default_nettype wire
